>>> hw/rtl/i2da_pkg.sv
// shared types and constants for the integer to decimal text converter
package i2da_pkg;

    // width of one packed decimal digit
    localparam int DIGIT_W = 4;
    // width of one text character
    localparam int CHAR_W = 8;
    // width of the raw value field on the request channel
    localparam int NUMBER_W = 64;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CONV = 5'b00010,
        ST_SKIP = 5'b00100,
        ST_SIGN = 5'b01000,
        ST_EMIT = 5'b10000
    } i2da_state_t;

endpackage

>>> hw/rtl/i2da_if.sv
// request and response channel interfaces of the converter

interface i2da_req_if;
    logic                            valid;
    logic                            ready;
    logic [i2da_pkg::NUMBER_W-1:0]   number_bits;
    logic                            action;

    modport source (output valid, output number_bits, output action, input ready);
    modport sink   (input valid, input number_bits, input action, output ready);
endinterface

interface i2da_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [i2da_pkg::CHAR_W-1:0]     text_char;
    logic                            last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

>>> hw/rtl/int_to_decimal_ascii.sv
// top level: integer to decimal ascii text converter
//
// req carries one integer (number_bits, low VALUE_WIDTH bits used) and a mode
// flag (action: 0 unsigned, 1 signed two's complement). rsp returns the decimal
// text one character per transaction, most significant first, with last_char
// set on the final character. A negative value is preceded by '-'; zero gives
// a single '0'.
// One transaction on req is handled at a time: req.ready is high only while
// the sequencer is idle. The conversion shifts each of the VALUE_WIDTH bits
// through the shared shift-and-add-3 unit, then leading zero digits are dropped
// one per cycle, keeping at least one, then one character is loaded per cycle
// while the response register is free. Skipped and emitted digits always add up
// to NDIG.
// The response register parts the two sides: a stall on rsp holds the current
// character and pauses the sequencer, and the final character may still wait
// there while the next request is taken.
// Reset clears the sequencer and the response valid; nothing else is kept
// between items.
module int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    i2da_req_if.sink          req,
    i2da_rsp_if.source        rsp
);
    import i2da_pkg::*;

    // decimal digits needed for the largest unsigned value
    localparam int NDIG  = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BCD_W = NDIG * DIGIT_W;
    localparam int BCW   = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int DCW   = $clog2(NDIG + 1);

    i2da_state_t             state_reg, state_next;
    logic [VALUE_WIDTH-1:0]  mag_reg, mag_next;
    logic [BCD_W-1:0]        bcd_reg, bcd_next;
    logic [BCW-1:0]          bit_cnt_reg, bit_cnt_next;
    logic [DCW-1:0]          dig_cnt_reg, dig_cnt_next;
    logic                    neg_reg, neg_next;
    logic                    out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]       out_char_reg, out_char_next;
    logic                    out_last_reg, out_last_next;

    logic [VALUE_WIDTH-1:0]  value;
    logic                    value_neg;
    logic [BCD_W-1:0]        bcd_step;
    logic [DIGIT_W-1:0]      top_digit;
    logic                    out_free;
    logic                    req_fire;

    // shared conversion unit
    i2da_dabble #(
        .NDIG (NDIG)
    ) u_dabble (
        .bcd      (bcd_reg),
        .bit_in   (mag_reg[VALUE_WIDTH-1]),
        .bcd_next (bcd_step)
    );

    // request decode: width cut, sign and magnitude
    assign value     = req.number_bits[VALUE_WIDTH-1:0];
    assign value_neg = req.action & value[VALUE_WIDTH-1];
    assign req_fire  = req.valid & req.ready;
    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign out_free  = ~out_valid_reg | rsp.ready;

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.text_char = out_char_reg;
    assign rsp.last_char = out_last_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg & ~rsp.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    neg_next     = value_neg;
                    mag_next     = value_neg ? (~value + VALUE_WIDTH'(1)) : value;
                    bcd_next     = '0;
                    bit_cnt_next = BCW'(VALUE_WIDTH - 1);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next     = bcd_step;
                mag_next     = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BCW'(1);
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DCW'(NDIG);
                    state_next   = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zero digits, keeping at least one
                if ((top_digit == '0) && (dig_cnt_reg > DCW'(1)))
                begin
                    bcd_next     = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    dig_cnt_next = dig_cnt_reg - DCW'(1);
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO + CHAR_W'(top_digit);
                    out_last_next  = (dig_cnt_reg == DCW'(1));
                    bcd_next       = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    dig_cnt_next   = dig_cnt_reg - DCW'(1);
                    if (dig_cnt_reg == DCW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        bit_cnt_reg  <= bit_cnt_next;
        dig_cnt_reg  <= dig_cnt_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    // every packed digit stays a decimal digit
    logic [NDIG-1:0] digit_ok;

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            digit_ok[i] = (bcd_reg[i*DIGIT_W +: DIGIT_W] <= DIGIT_W'(9));
        end
    end

    a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SKIP || state_reg == ST_EMIT) |-> (&digit_ok))
        else $error("packed digit out of decimal range");

    a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == ST_CONV))
        else $error("accepted request did not start conversion");

    a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=>
            (rsp.valid && $stable(rsp.text_char) && $stable(rsp.last_char)))
        else $error("response changed while stalled");

    a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (dig_cnt_reg != '0))
        else $error("emit state with no digits left");

endmodule

>>> hw/rtl/i2da_dabble.sv
// one shift-and-add-3 step of the binary to packed decimal conversion
module i2da_dabble #(
    parameter int NDIG = 20
) (
    input  logic [NDIG*i2da_pkg::DIGIT_W-1:0] bcd,
    input  logic                              bit_in,
    output logic [NDIG*i2da_pkg::DIGIT_W-1:0] bcd_next
);
    import i2da_pkg::*;

    logic [NDIG*DIGIT_W-1:0] adjusted;

    // digits of five or more get three added before the doubling
    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
            begin
                adjusted[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
            else
            begin
                adjusted[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // double and bring in the next binary bit
    assign bcd_next = {adjusted[NDIG*DIGIT_W-2:0], bit_in};

endmodule
